FILE: rtl/hilbert_tile_descriptor_gen_unit_defines.svh
// Assertion macros for the Hilbert tile descriptor generator.
// Used by the top level only; needs clk and arst_n in scope at the point of use.
`ifndef HILBERT_TILE_DESCRIPTOR_GEN_UNIT_DEFINES_SVH
`define HILBERT_TILE_DESCRIPTOR_GEN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, reset-qualified
`define HTDG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified
`define HTDG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define HTDG_ASSERT_IMP(lbl, ante, cons, msg)
`define HTDG_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/htdg_pkg.sv
// Shared types and constants of the Hilbert tile descriptor generator.
// No dependencies; imported by the interfaces and every module.
package htdg_pkg;

	localparam int CURVE_W = 16;
	localparam int COORD_W = 8;
	localparam int LVL_W   = 4;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 18;
	localparam int REG_W   = 3;

	localparam logic [WORD_W-1:0] W_COORD = 32'hB800_0000;
	localparam logic [WORD_W-1:0] W_ADDR  = 32'hE000_0002;
	localparam logic [WORD_W-1:0] W_MASK  = 32'hE000_0003;
	localparam logic [WORD_W-1:0] W_FIXED = 32'hB000_0000;
	localparam logic [WORD_W-1:0] W_END   = 32'hBC00_0000;

	typedef enum logic [REG_W-1:0] {
		REG_TILES_WIDE   = 3'd0,
		REG_TILES_HIGH   = 3'd1,
		REG_SHIFT_X      = 3'd2,
		REG_SHIFT_Y      = 3'd3,
		REG_BLOCKS_WIDE  = 3'd4,
		REG_BLOCK_BYTES  = 3'd5,
		REG_BASE_ADDRESS = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		SLOT_ZERO_A = 3'd0,
		SLOT_COORD  = 3'd1,
		SLOT_ADDR   = 3'd2,
		SLOT_FIXED  = 3'd3,
		SLOT_ZERO_B = 3'd4,
		SLOT_END    = 3'd5
	} slot_t;

	typedef struct packed {
		logic [8:0]  tiles_wide;
		logic [8:0]  tiles_high;
		logic [3:0]  shift_x;
		logic [3:0]  shift_y;
		logic [8:0]  blocks_wide;
		logic [15:0] block_bytes;
		logic [31:0] base_address;
	} cfg_t;

	// Payload carried along the row of curve cells
	typedef struct packed {
		logic [CURVE_W-1:0] d;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               in_range;
		logic               fin;
	} cell_t;

	// Tile descriptor handed to the word serialiser
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [WORD_W-1:0]  off;
		logic               vis;
		logic               fin;
	} desc_t;

endpackage

FILE: rtl/htdg_if.sv
// Channel interfaces of the Hilbert tile descriptor generator: index input,
// descriptor word output and configuration write. Depends on htdg_pkg.
interface htdg_item_if import htdg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CURVE_W-1:0] curve_index;
	logic               final_req;

	modport source (output valid, curve_index, final_req, input ready);
	modport sink   (input valid, curve_index, final_req, output ready);
endinterface

interface htdg_word_if import htdg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              last;

	modport source (output valid, word, last, input ready);
	modport sink   (input valid, word, last, output ready);
endinterface

interface htdg_cfg_if import htdg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [REG_W-1:0]  index;
	logic [WORD_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/htdg_cell.sv
// One level of the Hilbert index-to-coordinate walk, with its own stage register.
// Depends on htdg_pkg.
module htdg_cell import htdg_pkg::*; #(
	parameter int LEVEL = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LVL_W-1:0] levels,
	input  logic             in_valid,
	output logic             in_ready,
	input  cell_t            in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output cell_t            out_data
);

	localparam logic [COORD_W-1:0] MASK = COORD_W'((1 << LEVEL) - 1);
	localparam logic [COORD_W-1:0] BIT  = COORD_W'(1 << LEVEL);

	logic  valid_s1;
	cell_t data_s1;
	cell_t nxt;

	always_comb begin
		logic rx;
		logic ry;
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
		rx  = in_data.d[2*LEVEL+1];
		ry  = in_data.d[2*LEVEL] ^ rx;
		tx  = rx ? (~in_data.x & MASK) : in_data.x;
		ty  = rx ? (~in_data.y & MASK) : in_data.y;
		nxt = in_data;
		if (LVL_W'(LEVEL) < levels) begin
			if (!ry) begin
				nxt.x = ty;
				nxt.y = tx;
			end
			// coordinates stay below the current side, so OR adds the quadrant bit
			if (rx) nxt.x = nxt.x | BIT;
			if (ry) nxt.y = nxt.y | BIT;
		end
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

FILE: rtl/htdg_offset.sv
// Visibility test and bin block byte offset, two multiply stages.
// Depends on htdg_pkg.
module htdg_offset import htdg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  cell_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output desc_t out_data
);

	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic               vis_s1;
	logic               fin_s1;
	logic               valid_s2;
	desc_t              desc_s2;
	logic               rdy_s2;
	logic [COORD_W-1:0] ys;
	logic [COORD_W-1:0] xs;
	logic [IDX_W-1:0]   idx;
	logic               vis;

	assign ys  = in_data.y >> cfg.shift_y;
	assign xs  = in_data.x >> cfg.shift_x;
	assign idx = IDX_W'(ys) * IDX_W'(cfg.blocks_wide) + IDX_W'(xs);
	assign vis = in_data.in_range
		&& ({1'b0, in_data.x} < cfg.tiles_wide)
		&& ({1'b0, in_data.y} < cfg.tiles_high);

	assign rdy_s2    = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || rdy_s2;
	assign out_valid = valid_s2;
	assign out_data  = desc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (rdy_s2)   valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			idx_s1 <= idx;
			x_s1   <= in_data.x;
			y_s1   <= in_data.y;
			vis_s1 <= vis;
			fin_s1 <= in_data.fin;
		end
		if (rdy_s2 && valid_s1) begin
			desc_s2.off <= WORD_W'(idx_s1) * WORD_W'(cfg.block_bytes);
			desc_s2.x   <= x_s1;
			desc_s2.y   <= y_s1;
			desc_s2.vis <= vis_s1;
			desc_s2.fin <= fin_s1;
		end
	end

endmodule

FILE: rtl/htdg_serializer.sv
// Turns one tile descriptor into its run of descriptor words, one per cycle unless out stalls.
// Depends on htdg_pkg and htdg_word_if.
module htdg_serializer import htdg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] base_address,
	input  logic              in_valid,
	output logic              in_ready,
	input  desc_t             in_data,
	htdg_word_if.source       out
);

	logic              busy_q;
	slot_t             slot_q;
	slot_t             slot_nxt;
	logic              fin_q;
	logic [WORD_W-1:0] coord_q;
	logic [WORD_W-1:0] addr_q;
	logic              last;
	logic              load;
	logic              take;

	assign last     = (slot_q == SLOT_END) || ((slot_q == SLOT_FIXED) && !fin_q);
	assign take     = out.valid && out.ready;
	assign in_ready = !busy_q || (out.ready && last);
	assign load     = in_valid && in_ready;

	assign out.valid = busy_q;
	assign out.last  = last;

	always_comb begin
		unique case (slot_q)
			SLOT_ZERO_A: slot_nxt = SLOT_COORD;
			SLOT_COORD:  slot_nxt = SLOT_ADDR;
			SLOT_ADDR:   slot_nxt = SLOT_FIXED;
			SLOT_FIXED:  slot_nxt = SLOT_ZERO_B;
			SLOT_ZERO_B: slot_nxt = SLOT_END;
			SLOT_END:    slot_nxt = SLOT_END;
			default:     slot_nxt = SLOT_END;
		endcase
	end

	always_comb begin
		unique case (slot_q)
			SLOT_ZERO_A: out.word = '0;
			SLOT_COORD:  out.word = coord_q;
			SLOT_ADDR:   out.word = addr_q;
			SLOT_FIXED:  out.word = W_FIXED;
			SLOT_ZERO_B: out.word = '0;
			SLOT_END:    out.word = W_END;
			default:     out.word = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_ZERO_A;
		end else if (load) begin
			busy_q <= 1'b1;
			slot_q <= in_data.vis ? SLOT_ZERO_A : SLOT_ZERO_B;
		end else if (take) begin
			if (last) busy_q <= 1'b0;
			else      slot_q <= slot_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			fin_q   <= in_data.fin;
			coord_q <= W_COORD | {16'b0, in_data.y, in_data.x};
			addr_q  <= (W_ADDR | ({3'b0, in_data.off[WORD_W-1:3]} & ~W_MASK))
				+ {3'b0, base_address[WORD_W-1:3]};
		end
	end

endmodule

FILE: rtl/hilbert_tile_descriptor_gen_unit.sv
// Hilbert tile descriptor generator, top level: configuration registers, the
// row of curve cells, offset stages and the word serialiser. Depends on htdg_pkg,
// the htdg interfaces, htdg_cell, htdg_offset, htdg_serializer and the defines header.
//
// Each transaction on item carries a curve index and a final flag. The index
// walks a row of MAX_LEVELS cells, one curve level per cell, giving the tile
// (x, y) on a square grid whose side is the smallest power of two covering
// tiles_wide and tiles_high. Two further stages test the tile against the area
// and form its bin block byte offset (one multiplier each), and the serialiser
// then emits the words: 0, coordinate, address, 0xB0000000 for a visible tile,
// and 0, 0xBC000000 after them when the index was final; last marks the final
// word of each run. The serialiser emits one word per cycle while desc is ready,
// so it sets the rate, taking a new descriptor only with the last word of the
// run; an index that yields nothing is dropped and passes at one per cycle.
// Every stage holds its own transaction and takes a new one as soon as its
// neighbour moves on, so indexes can be offered on every cycle. The first word
// passes the cell, offset and serialiser registers. Configuration writes are
// always accepted; change registers only while the block is idle.
`include "hilbert_tile_descriptor_gen_unit_defines.svh"

module hilbert_tile_descriptor_gen_unit import htdg_pkg::*; #(
	parameter int MAX_LEVELS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	htdg_cfg_if.sink   cfg,
	htdg_item_if.sink  item,
	htdg_word_if.source desc
);

	// Configuration registers
	logic [8:0]  tiles_wide_q;
	logic [8:0]  tiles_high_q;
	logic [3:0]  shift_x_q;
	logic [3:0]  shift_y_q;
	logic [8:0]  blocks_wide_q;
	logic [15:0] block_bytes_q;
	logic [31:0] base_address_q;
	cfg_t        cfg_w;

	logic [8:0]       mx;
	logic [LVL_W-1:0] levels;
	logic             in_range;

	// Cell row: slot 0 is the input channel, slot g+1 is the output of cell g
	logic  cv   [0:MAX_LEVELS];
	logic  crdy [0:MAX_LEVELS];
	cell_t cdat [0:MAX_LEVELS];

	logic  off_v;
	logic  off_rdy;
	desc_t off_desc;
	logic  ser_v;
	logic  ser_rdy;
	logic  keep;

	// Accept every write; indexes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_wide_q   <= 9'd1;
			tiles_high_q   <= 9'd1;
			shift_x_q      <= 4'd0;
			shift_y_q      <= 4'd0;
			blocks_wide_q  <= 9'd1;
			block_bytes_q  <= 16'd512;
			base_address_q <= 32'd0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TILES_WIDE:   tiles_wide_q   <= cfg.data[8:0];
				REG_TILES_HIGH:   tiles_high_q   <= cfg.data[8:0];
				REG_SHIFT_X:      shift_x_q      <= cfg.data[3:0];
				REG_SHIFT_Y:      shift_y_q      <= cfg.data[3:0];
				REG_BLOCKS_WIDE:  blocks_wide_q  <= cfg.data[8:0];
				REG_BLOCK_BYTES:  block_bytes_q  <= cfg.data[15:0];
				REG_BASE_ADDRESS: base_address_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg_w = '{
		tiles_wide:   tiles_wide_q,
		tiles_high:   tiles_high_q,
		shift_x:      shift_x_q,
		shift_y:      shift_y_q,
		blocks_wide:  blocks_wide_q,
		block_bytes:  block_bytes_q,
		base_address: base_address_q
	};

	// Grid level count: ceil(log2(max(width, height))), held at MAX_LEVELS
	assign mx = (tiles_wide_q > tiles_high_q) ? tiles_wide_q : tiles_high_q;

	always_comb begin
		levels = '0;
		for (int l = 0; l < MAX_LEVELS; l++) begin
			if ((9'd1 << l) < mx) levels = LVL_W'(l + 1);
		end
	end

	// Index beyond the grid square gives no tile
	assign in_range = {1'b0, item.curve_index} < (17'd1 << {levels, 1'b0});

	assign cv[0]            = item.valid;
	assign item.ready       = crdy[0];
	assign cdat[0].d        = item.curve_index;
	assign cdat[0].x        = '0;
	assign cdat[0].y        = '0;
	assign cdat[0].in_range = in_range;
	assign cdat[0].fin      = item.final_req;

	for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cell
		htdg_cell #(
			.LEVEL(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.levels    (levels),
			.in_valid  (cv[g]),
			.in_ready  (crdy[g]),
			.in_data   (cdat[g]),
			.out_valid (cv[g+1]),
			.out_ready (crdy[g+1]),
			.out_data  (cdat[g+1])
		);
	end

	htdg_offset u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_w),
		.in_valid  (cv[MAX_LEVELS]),
		.in_ready  (crdy[MAX_LEVELS]),
		.in_data   (cdat[MAX_LEVELS]),
		.out_valid (off_v),
		.out_ready (off_rdy),
		.out_data  (off_desc)
	);

	// Drop descriptors that produce no words; pass the rest to the serialiser
	assign keep    = off_desc.vis || off_desc.fin;
	assign ser_v   = off_v && keep;
	assign off_rdy = ser_rdy || !keep;

	htdg_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.base_address (base_address_q),
		.in_valid     (ser_v),
		.in_ready     (ser_rdy),
		.in_data      (off_desc),
		.out          (desc)
	);

	`HTDG_ASSERT_NXT(a_item_enters_row, item.valid && item.ready, cv[1], "accepted index lost at cell row entry")
	`HTDG_ASSERT_IMP(a_vis_in_area, off_v && off_desc.vis, ({1'b0, off_desc.x} < tiles_wide_q) && ({1'b0, off_desc.y} < tiles_high_q), "visible tile outside the area")
	`HTDG_ASSERT_NXT(a_run_contiguous, desc.valid && desc.ready && !desc.last, desc.valid, "word run broken before its last word")

endmodule

FILE: test/htdg_desc_checker.sv
// Scoreboard for the Hilbert tile descriptor generator: watches the configuration,
// index and descriptor word channels, predicts every word and compares.
// Depends on htdg_pkg and the htdg channel interfaces.
module htdg_desc_checker import htdg_pkg::*; #(
	parameter int MAX_LEVELS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	htdg_cfg_if   cfg,
	htdg_item_if  item,
	htdg_word_if  desc,
	output int    errors,
	output int    pending
);

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} desc_word_t;

	cfg_t       regs;
	desc_word_t due_words[$];
	int         n_bad  = 0;
	int         n_open = 0;
	int         n_seen = 0;

	assign errors  = n_bad;
	assign pending = n_open;

	function automatic int unsigned grid_levels(input cfg_t c);
		logic [8:0]  span;
		int unsigned lv;
		span = (c.tiles_wide > c.tiles_high) ? c.tiles_wide : c.tiles_high;
		lv = 0;
		while (lv < MAX_LEVELS && (32'd1 << lv) < 32'(span))
			lv++;
		return lv;
	endfunction

	// Walk the curve from the finest level upwards, rotating the partial tile
	function automatic void curve_to_tile(input int unsigned lv, input logic [31:0] d,
		output logic [31:0] x, output logic [31:0] y);
		logic [31:0] t, rx, ry, swap;
		x = '0;
		y = '0;
		t = d;
		for (int s = 0; s < lv; s++) begin
			rx = 32'd1 & (t >> 1);
			ry = 32'd1 & (t ^ rx);
			if (ry == 0) begin
				if (rx == 1) begin
					x = (32'd1 << s) - 32'd1 - x;
					y = (32'd1 << s) - 32'd1 - y;
				end
				swap = x;
				x = y;
				y = swap;
			end
			x = x + (rx << s);
			y = y + (ry << s);
			t = t >> 2;
		end
	endfunction

	function automatic void predict_descriptors(input cfg_t c, input logic [CURVE_W-1:0] d,
		input logic fin);
		logic [WORD_W-1:0] words[6];
		logic [31:0]       x, y, off;
		int unsigned       lv;
		int                n;
		desc_word_t        w;
		n = 0;
		lv = grid_levels(c);
		if (32'(d) < (32'd1 << (2 * lv))) begin
			curve_to_tile(lv, 32'(d), x, y);
			if (x < 32'(c.tiles_wide) && y < 32'(c.tiles_high)) begin
				off = ((y >> c.shift_y) * 32'(c.blocks_wide) + (x >> c.shift_x))
					* 32'(c.block_bytes);
				words[0] = '0;
				words[1] = W_COORD | x | (y << 8);
				words[2] = (W_ADDR | ((off >> 3) & ~W_MASK)) + (c.base_address >> 3);
				words[3] = W_FIXED;
				n = 4;
			end
		end
		if (fin) begin
			words[n] = '0;
			words[n + 1] = W_END;
			n = n + 2;
		end
		for (int k = 0; k < n; k++) begin
			w.word = words[k];
			w.last = (k == n - 1);
			due_words.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		desc_word_t want;
		if (!arst_n) begin
			regs.tiles_wide   = 9'd1;
			regs.tiles_high   = 9'd1;
			regs.shift_x      = 4'd0;
			regs.shift_y      = 4'd0;
			regs.blocks_wide  = 9'd1;
			regs.block_bytes  = 16'd512;
			regs.base_address = 32'd0;
			due_words.delete();
		end else begin
			if (desc.valid && desc.ready) begin
				if (due_words.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected word %0d: word %h last %b", n_seen,
							desc.word, desc.last);
				end else begin
					want = due_words.pop_front();
					if (want.word !== desc.word || want.last !== desc.last) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch at word %0d: expected word %h last %b, got word %h last %b",
								n_seen, want.word, want.last, desc.word, desc.last);
					end
				end
				n_seen++;
			end
			if (item.valid && item.ready)
				predict_descriptors(regs, item.curve_index, item.final_req);
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_TILES_WIDE:   regs.tiles_wide   = cfg.data[8:0];
					REG_TILES_HIGH:   regs.tiles_high   = cfg.data[8:0];
					REG_SHIFT_X:      regs.shift_x      = cfg.data[3:0];
					REG_SHIFT_Y:      regs.shift_y      = cfg.data[3:0];
					REG_BLOCKS_WIDE:  regs.blocks_wide  = cfg.data[8:0];
					REG_BLOCK_BYTES:  regs.block_bytes  = cfg.data[15:0];
					REG_BASE_ADDRESS: regs.base_address = cfg.data;
					default: ;
				endcase
			end
		end
		n_open = due_words.size();
	end

endmodule

FILE: test/tb_top.sv
// Testbench top for hilbert_tile_descriptor_gen_unit: clock, reset, stimulus
// and verdict; prediction and comparison live in htdg_desc_checker.
// Depends on htdg_pkg, the htdg channel interfaces and the checker.
module tb_top;
	import htdg_pkg::*;

	localparam int MAX_LEVELS  = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 75;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	htdg_cfg_if  cfg_ch();
	htdg_item_if item_ch();
	htdg_word_if desc_ch();

	int   errors;
	int   pending;
	int   cycles    = 0;
	bit   idle_on   = 1'b1;
	int   hold_req  = 0;
	cfg_t cur;
	cfg_t plan[6];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	hilbert_tile_descriptor_gen_unit #(.MAX_LEVELS(MAX_LEVELS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.desc   (desc_ch)
	);

	htdg_desc_checker #(.MAX_LEVELS(MAX_LEVELS)) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.item    (item_ch),
		.desc    (desc_ch),
		.errors  (errors),
		.pending (pending)
	);

	// Hard stop: a hung handshake or a missing word ends up here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Word receiver: random back-pressure, plus a long hold-off on request.
	// The hold is counted here so the sender keeps offering indexes meanwhile
	// and the pipeline fills up until it stalls its input.
	initial begin
		int hold_ack;
		int hold_left;
		hold_ack = 0;
		hold_left = 0;
		desc_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				desc_ch.ready = 1'b0;
				hold_left--;
			end else if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES - 1;
				desc_ch.ready = 1'b0;
			end else begin
				desc_ch.ready = !idle_on || ($urandom_range(99) >= 14);
			end
		end
	end

	function automatic cfg_t make_cfg(input int tw, input int th, input int sx, input int sy,
		input int bw, input int bb, input logic [31:0] base);
		cfg_t c;
		c.tiles_wide   = 9'(tw);
		c.tiles_high   = 9'(th);
		c.shift_x      = 4'(sx);
		c.shift_y      = 4'(sy);
		c.blocks_wide  = 9'(bw);
		c.block_bytes  = 16'(bb);
		c.base_address = base;
		return c;
	endfunction

	// Bias indexes into the current grid so most of them land on real tiles;
	// one in ten ranges over the whole field to hit the beyond-grid case.
	function automatic logic [CURVE_W-1:0] pick_index();
		int unsigned span;
		int unsigned lv;
		span = (cur.tiles_wide > cur.tiles_high) ? cur.tiles_wide : cur.tiles_high;
		lv = $clog2(span);
		if (lv > MAX_LEVELS)
			lv = MAX_LEVELS;
		if ($urandom_range(9) == 0)
			return CURVE_W'($urandom);
		return CURVE_W'($urandom_range((1 << (2 * lv)) - 1));
	endfunction

	// Offer one index; idle first at random, then hold until the transaction is taken
	task automatic push_index(input logic [CURVE_W-1:0] d, input logic fin);
		while (idle_on && $urandom_range(99) < 14) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid       = 1'b1;
		item_ch.curve_index = d;
		item_ch.final_req   = fin;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	// Stop offering, wait for every expected word, then idle on so that an index
	// that yields nothing also leaves the pipeline
	task automatic settle();
		item_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (MAX_LEVELS + 6) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = r;
		cfg_ch.data  = v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	// Only called with the block idle
	task automatic apply_settings(input cfg_t c);
		write_reg(REG_TILES_WIDE,   32'(c.tiles_wide));
		write_reg(REG_TILES_HIGH,   32'(c.tiles_high));
		write_reg(REG_SHIFT_X,      32'(c.shift_x));
		write_reg(REG_SHIFT_Y,      32'(c.shift_y));
		write_reg(REG_BLOCKS_WIDE,  32'(c.blocks_wide));
		write_reg(REG_BLOCK_BYTES,  32'(c.block_bytes));
		write_reg(REG_BASE_ADDRESS, c.base_address);
		cfg_ch.valid = 1'b0;
		cur = c;
	endtask

	initial begin
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_TILES_WIDE;
		cfg_ch.data         = '0;
		item_ch.valid       = 1'b0;
		item_ch.curve_index = '0;
		item_ch.final_req   = 1'b0;
		cur = make_cfg(1, 1, 0, 0, 1, 512, 32'h0000_0000);

		// Typical, largest grid, all minima, oversized fields, zero width, mid-size
		plan[0] = make_cfg(13, 9, 2, 1, 4, 768, 32'h8000_0010);
		plan[1] = make_cfg(256, 256, 8, 8, 256, 65535, 32'hFFFF_FFFF);
		plan[2] = make_cfg(1, 1, 0, 0, 1, 0, 32'h0000_0000);
		plan[3] = make_cfg(511, 2, 15, 15, 511, 1, 32'h0000_0007);
		plan[4] = make_cfg(0, 37, 3, 0, 0, 16'h1234, 32'h1234_5678);
		plan[5] = make_cfg(100, 200, 4, 5, 7, 4096, 32'h4000_0000);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: a one-tile grid, so only index zero is a tile
		push_index(16'd0, 1'b0);
		push_index(16'd0, 1'b1);
		push_index(16'd1, 1'b1);
		push_index(16'hFFFF, 1'b0);
		settle();

		// 5 x 3 area on an 8 x 8 grid: tiles inside, outside, beyond the grid
		apply_settings(make_cfg(5, 3, 1, 1, 3, 512, 32'h1000_0008));
		push_index(16'd0, 1'b0);
		push_index(16'd1, 1'b0);
		push_index(16'd2, 1'b0);
		push_index(16'd3, 1'b0);
		push_index(16'd14, 1'b0);
		push_index(16'd63, 1'b0);
		push_index(16'd63, 1'b1);
		push_index(16'd64, 1'b0);
		push_index(16'd64, 1'b1);
		push_index(16'h5555, 1'b0);
		push_index(16'hAAAA, 1'b1);
		push_index(16'hFFFF, 1'b1);
		push_index(16'd0, 1'b1);
		settle();

		for (int p = 0; p < 6; p++) begin
			apply_settings(plan[p]);
			// Run the largest-grid phase with no idling on either side
			idle_on = (p != 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 5 && i == 10)
					hold_req++;
				push_index(pick_index(), $urandom_range(4) == 0);
			end
			settle();
		end
		idle_on = 1'b1;

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
